>>> rtl/fts_pkg.sv
// Shared constants, codes and types for the fan tachometer speed monitor.
`default_nettype none
package fts_pkg;

    localparam int FAN_SLOTS = 8;
    localparam int SLOT_W    = (FAN_SLOTS > 1) ? $clog2(FAN_SLOTS) : 1;
    localparam int IDX_W     = 3;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 16;
    localparam int SLOW_W    = 7;
    localparam int SPD_W     = 8;
    localparam int ELAP_W    = 16;
    localparam int DIV_BITS  = SPD_W;
    localparam int BIT_W     = $clog2(DIV_BITS);
    localparam int NUM_W     = ELAP_W + DIV_BITS;

    localparam logic [SPD_W-1:0] RPS_SCALE = 8'd250;
    localparam logic [SPD_W-1:0] RPS_MAX   = 8'd255;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_DETECTED = 2'd1;
    localparam logic [1:0] MODE_REPORTED = 2'd2;
    localparam logic [1:0] MODE_FIXED    = 2'd3;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [1:0] CFG_CHECK_EN  = 2'd0;
    localparam logic [1:0] CFG_PRESENT   = 2'd1;
    localparam logic [1:0] CFG_ERR_LIMIT = 2'd2;
    localparam logic [1:0] CFG_MIN_SPEED = 2'd3;

    typedef struct packed {
        logic             sample;
        logic             measuring;
        logic             load;
        logic             ovf;
        logic             step;
        logic             fin;
        logic [BIT_W-1:0] bit_idx;
    } t_lane_ctl;

    typedef struct packed {
        logic              check_en;
        logic [SLOW_W-1:0] err_limit;
        logic [SPD_W-1:0]  min_speed;
    } t_lane_cfg;

    typedef struct packed {
        logic win;
        logic emit;
    } t_merge_ctl;

    typedef logic [FAN_SLOTS-1:0][SPD_W-1:0] t_speed_arr;

endpackage
`default_nettype wire

>>> rtl/fts_lane.sv
// One fan slot: edge counter, speed divider and slow-window counter.
`default_nettype none
module fts_lane (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  fts_pkg::t_lane_ctl          i_ctl,
    input  fts_pkg::t_lane_cfg          i_cfg,
    input  wire                         i_present,
    input  wire                         i_level,
    input  wire                         i_afoff,
    input  wire [fts_pkg::ELAP_W-1:0]   i_elapsed,
    output logic [fts_pkg::SPD_W-1:0]   o_speed,
    output logic                        o_fault
);
    import fts_pkg::*;

    logic              r_last_level;
    logic [CNT_W-1:0]  r_edge_count;
    logic [SLOW_W-1:0] r_slow_count;
    logic              r_active;
    logic [NUM_W-1:0]  r_num;
    logic [SPD_W-1:0]  r_quo;
    logic              r_sat;
    logic              r_fault;

    logic [NUM_W-1:0]  w_div_shift;
    logic [NUM_W-1:0]  w_div_top;
    logic [SPD_W-1:0]  w_speed;

    assign w_div_shift = NUM_W'(i_elapsed) << i_ctl.bit_idx;
    assign w_div_top   = {i_elapsed, {DIV_BITS{1'b0}}};
    assign w_speed     = r_sat ? RPS_MAX : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_edge_count <= '0;
            r_slow_count <= '0;
            r_active     <= 1'b0;
        end else begin
            if (i_ctl.sample && i_present && (i_level != r_last_level)) begin
                r_last_level <= i_level;
                if (i_ctl.measuring && (r_edge_count != CNT_MAX)) begin
                    r_edge_count <= r_edge_count + 1'b1;
                end
            end
            if (i_ctl.load) begin
                r_active <= i_present;
                if (i_present) begin
                    r_edge_count <= '0;
                end
            end
            if (i_ctl.fin && r_active) begin
                if ((w_speed >= i_cfg.min_speed) || i_afoff) begin
                    r_slow_count <= '0;
                end else if (r_slow_count < i_cfg.err_limit) begin
                    r_slow_count <= r_slow_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= NUM_W'(r_edge_count) * NUM_W'(RPS_SCALE);
        end
        if (i_ctl.ovf) begin
            r_sat <= (i_elapsed == '0) || (r_num >= w_div_top);
            r_quo <= '0;
        end
        if (i_ctl.step && !r_sat && (r_num >= w_div_shift)) begin
            r_num                <= r_num - w_div_shift;
            r_quo[i_ctl.bit_idx] <= 1'b1;
        end
        if (i_ctl.fin) begin
            r_fault <= r_active && i_cfg.check_en && !(w_speed >= i_cfg.min_speed)
                       && !i_afoff && !(r_slow_count < i_cfg.err_limit);
        end
    end

    assign o_speed = r_active ? w_speed : '0;
    assign o_fault = r_fault;

endmodule
`default_nettype wire

>>> rtl/fts_merge.sv
// Window error state machine, fault reporting and per-slot result register.
`default_nettype none
module fts_merge (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  fts_pkg::t_merge_ctl             i_ctl,
    input  wire [fts_pkg::FAN_SLOTS-1:0]    i_fault,
    input  fts_pkg::t_speed_arr             i_speed,
    input  wire                             i_ongoing,
    input  wire                             i_paused,
    input  wire [fts_pkg::FAN_SLOTS-1:0]    i_heat,
    input  wire                             i_out_stall,
    output logic                            o_out_valid,
    output logic [fts_pkg::IDX_W-1:0]       o_fan_index,
    output logic [fts_pkg::SPD_W-1:0]       o_speed_rps,
    output logic                            o_fan_fault,
    output logic                            o_fault_reported,
    output logic                            o_request_kill,
    output logic                            o_heater_off,
    output logic [1:0]                      o_error_state,
    output logic                            o_clear_alert,
    output logic                            o_last,
    output logic                            o_done
);
    import fts_pkg::*;

    logic [1:0]           r_mode;
    logic [FAN_SLOTS-1:0] r_prev;
    logic                 r_clear;
    logic                 r_do_rep;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_out_valid;

    logic [IDX_W-1:0]     r_fan_index;
    logic [SPD_W-1:0]     r_speed;
    logic                 r_fan_fault;
    logic                 r_rep;
    logic                 r_kill;
    logic                 r_hoff;
    logic [1:0]           r_state_out;
    logic                 r_clear_out;
    logic                 r_last;

    logic [1:0]           n_win_mode;
    logic                 n_win_clear;
    logic [1:0]           n_mode;
    logic                 n_rep;
    logic                 n_kill;
    logic                 n_hoff;
    logic                 w_load;
    logic                 w_last_slot;

    always_comb begin
        n_win_mode  = r_mode;
        n_win_clear = 1'b0;
        if ((i_fault == '0) && (n_win_mode == MODE_REPORTED)) begin
            n_win_mode = MODE_FIXED;
        end
        if ((n_win_mode == MODE_FIXED) && !i_ongoing && !i_paused) begin
            n_win_mode  = MODE_NONE;
            n_win_clear = 1'b1;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_rep  = r_do_rep && i_fault[r_slot];
        n_kill = 1'b0;
        n_hoff = 1'b0;
        if (n_rep) begin
            if (i_ongoing) begin
                if (r_mode == MODE_NONE) begin
                    if (i_heat[r_slot]) begin
                        n_kill = 1'b1;
                        n_mode = MODE_REPORTED;
                    end else begin
                        n_mode = MODE_DETECTED;
                    end
                end
            end else if (!i_paused) begin
                n_hoff = 1'b1;
                if (r_mode == MODE_NONE) begin
                    n_mode = MODE_REPORTED;
                end
            end
        end
    end

    assign w_last_slot = (r_slot == SLOT_W'(FAN_SLOTS - 1));
    assign w_load      = i_ctl.emit && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_prev      <= '0;
            r_clear     <= 1'b0;
            r_do_rep    <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.win) begin
                r_mode   <= n_win_mode;
                r_clear  <= n_win_clear;
                r_do_rep <= (i_fault & ~r_prev) != '0;
                r_prev   <= i_fault;
                r_slot   <= '0;
            end
            if (w_load) begin
                r_mode      <= n_mode;
                r_slot      <= w_last_slot ? '0 : r_slot + 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_fan_index <= IDX_W'(r_slot);
            r_speed     <= i_speed[r_slot];
            r_fan_fault <= i_fault[r_slot];
            r_rep       <= n_rep;
            r_kill      <= n_kill;
            r_hoff      <= n_hoff;
            r_state_out <= n_mode;
            r_clear_out <= r_clear;
            r_last      <= w_last_slot;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fan_index      = r_fan_index;
    assign o_speed_rps      = r_speed;
    assign o_fan_fault      = r_fan_fault;
    assign o_fault_reported = r_rep;
    assign o_request_kill   = r_kill;
    assign o_heater_off     = r_hoff;
    assign o_error_state    = r_state_out;
    assign o_clear_alert    = r_clear_out;
    assign o_last           = r_last;
    assign o_done           = w_load && w_last_slot;

endmodule
`default_nettype wire

>>> rtl/fan_tacho_speed_monitor.sv
// Sample items give no result; one is accepted every cycle while idle.
// A compute item passes the overflow check, the divider (8 steps per lane, one
// quotient bit each), the fault check and the window update; it then gives
// one result per cycle over 8 slots unless the output stalls, before the next item.
// Synchronous active-low reset clears counts, error mode and fault history,
// and restores the configuration registers to their defaults.
`default_nettype none
module fan_tacho_speed_monitor (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [1:0]                     i_cfg_index,
    input  wire [fts_pkg::MASK_W-1:0]     i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_req_type,
    input  wire [fts_pkg::MASK_W-1:0]     i_tach_levels,
    input  wire                           i_measuring,
    input  wire [fts_pkg::ELAP_W-1:0]     i_elapsed_ms,
    input  wire                           i_job_ongoing,
    input  wire                           i_job_paused,
    input  wire [fts_pkg::MASK_W-1:0]     i_heater_target_mask,
    input  wire [fts_pkg::MASK_W-1:0]     i_autofan_off_mask,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [fts_pkg::IDX_W-1:0]     o_fan_index,
    output logic [fts_pkg::SPD_W-1:0]     o_speed_rps,
    output logic                          o_fan_fault,
    output logic                          o_fault_reported,
    output logic                          o_request_kill,
    output logic                          o_heater_off,
    output logic [1:0]                    o_error_state,
    output logic                          o_clear_alert,
    output logic                          o_last
);
    import fts_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OVF  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_WIN  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [BIT_W-1:0]     r_bit;

    logic                 r_check_en;
    logic [MASK_W-1:0]    r_present;
    logic [SLOW_W-1:0]    r_err_limit;
    logic [SPD_W-1:0]     r_min_speed;

    logic [ELAP_W-1:0]    r_elapsed;
    logic                 r_ongoing;
    logic                 r_paused;
    logic [MASK_W-1:0]    r_heat;
    logic [MASK_W-1:0]    r_afoff;

    logic                 w_accept;
    logic                 w_merge_done;
    t_lane_ctl            w_lane_ctl;
    t_lane_cfg            w_lane_cfg;
    t_merge_ctl           w_merge_ctl;
    t_speed_arr           w_speed;
    logic [FAN_SLOTS-1:0] w_fault;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en  <= 1'b0;
            r_present   <= 8'd1;
            r_err_limit <= 7'd5;
            r_min_speed <= 8'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHECK_EN:  r_check_en  <= i_cfg_data[0];
                CFG_PRESENT:   r_present   <= i_cfg_data;
                CFG_ERR_LIMIT: r_err_limit <= i_cfg_data[SLOW_W-1:0];
                CFG_MIN_SPEED: r_min_speed <= i_cfg_data;
                default:       r_check_en  <= r_check_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req_type == REQ_COMPUTE)) begin
            r_elapsed <= i_elapsed_ms;
            r_ongoing <= i_job_ongoing;
            r_paused  <= i_job_paused;
            r_heat    <= i_heater_target_mask;
            r_afoff   <= i_autofan_off_mask;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && (i_req_type == REQ_COMPUTE)) n_state = ST_OVF;
            ST_OVF:  n_state = ST_DIV;
            ST_DIV:  if (r_bit == '0) n_state = ST_FIN;
            ST_FIN:  n_state = ST_WIN;
            ST_WIN:  n_state = ST_EMIT;
            ST_EMIT: if (w_merge_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OVF) begin
                r_bit <= BIT_W'(DIV_BITS - 1);
            end else if (r_state == ST_DIV) begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    always_comb begin
        w_lane_ctl.sample    = w_accept && (i_req_type == REQ_SAMPLE);
        w_lane_ctl.measuring = i_measuring;
        w_lane_ctl.load      = w_accept && (i_req_type == REQ_COMPUTE);
        w_lane_ctl.ovf       = (r_state == ST_OVF);
        w_lane_ctl.step      = (r_state == ST_DIV);
        w_lane_ctl.fin       = (r_state == ST_FIN);
        w_lane_ctl.bit_idx   = r_bit;
        w_lane_cfg.check_en  = r_check_en;
        w_lane_cfg.err_limit = r_err_limit;
        w_lane_cfg.min_speed = r_min_speed;
        w_merge_ctl.win      = (r_state == ST_WIN);
        w_merge_ctl.emit     = (r_state == ST_EMIT);
    end

    genvar g;
    generate
        for (g = 0; g < FAN_SLOTS; g++) begin : g_lane
            fts_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_lane_ctl),
                .i_cfg     (w_lane_cfg),
                .i_present (r_present[g]),
                .i_level   (i_tach_levels[g]),
                .i_afoff   (r_afoff[g]),
                .i_elapsed (r_elapsed),
                .o_speed   (w_speed[g]),
                .o_fault   (w_fault[g])
            );
        end
    endgenerate

    fts_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_merge_ctl),
        .i_fault          (w_fault),
        .i_speed          (w_speed),
        .i_ongoing        (r_ongoing),
        .i_paused         (r_paused),
        .i_heat           (r_heat[FAN_SLOTS-1:0]),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_fan_index      (o_fan_index),
        .o_speed_rps      (o_speed_rps),
        .o_fan_fault      (o_fan_fault),
        .o_fault_reported (o_fault_reported),
        .o_request_kill   (o_request_kill),
        .o_heater_off     (o_heater_off),
        .o_error_state    (o_error_state),
        .o_clear_alert    (o_clear_alert),
        .o_last           (o_last),
        .o_done           (w_merge_done)
    );

    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_COMPUTE)) |=> o_in_stall)
        else $error("compute item not followed by input stall");

    a_sample_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_SAMPLE) && !o_out_valid) |=> !o_out_valid)
        else $error("sample item produced a result");

    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> o_out_valid)
        else $error("gap inside a result burst");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result appeared while idle");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for fan_tacho_speed_monitor: directed and random windows.
`timescale 1ns / 1ps
module tb_top;
    import fts_pkg::*;

    typedef struct packed {
        logic        req;
        logic [7:0]  levels;
        logic        meas;
        logic [15:0] elapsed;
        logic        ongoing;
        logic        paused;
        logic [7:0]  heat;
        logic [7:0]  afoff;
    } tacho_item_t;

    typedef struct packed {
        tacho_item_t it;
        logic        typed;
        logic [7:0]  rps0;
    } tacho_row_t;

    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] rps;
        logic       fault;
        logic       rep;
        logic       kill;
        logic       hoff;
        logic [1:0] mode;
        logic       clr;
        logic       last;
    } slot_report_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_CHECK_EN;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = REQ_SAMPLE;
    logic [7:0]  i_tach_levels = '0;
    logic        i_measuring = 1'b0;
    logic [15:0] i_elapsed_ms = '0;
    logic        i_job_ongoing = 1'b0;
    logic        i_job_paused = 1'b0;
    logic [7:0]  i_heater_target_mask = '0;
    logic [7:0]  i_autofan_off_mask = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_fan_index;
    logic [7:0]  o_speed_rps;
    logic        o_fan_fault;
    logic        o_fault_reported;
    logic        o_request_kill;
    logic        o_heater_off;
    logic [1:0]  o_error_state;
    logic        o_clear_alert;
    logic        o_last;

    fan_tacho_speed_monitor u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_tach_levels        (i_tach_levels),
        .i_measuring          (i_measuring),
        .i_elapsed_ms         (i_elapsed_ms),
        .i_job_ongoing        (i_job_ongoing),
        .i_job_paused         (i_job_paused),
        .i_heater_target_mask (i_heater_target_mask),
        .i_autofan_off_mask   (i_autofan_off_mask),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_fan_index          (o_fan_index),
        .o_speed_rps          (o_speed_rps),
        .o_fan_fault          (o_fan_fault),
        .o_fault_reported     (o_fault_reported),
        .o_request_kill       (o_request_kill),
        .o_heater_off         (o_heater_off),
        .o_error_state        (o_error_state),
        .o_clear_alert        (o_clear_alert),
        .o_last               (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow configuration and monitor state
    logic        chk_en_q;
    logic [7:0]  present_q;
    logic [6:0]  err_lim_q;
    logic [7:0]  min_spd_q;
    logic        lvl_q   [FAN_SLOTS];
    logic [15:0] edges_q [FAN_SLOTS];
    logic [6:0]  slow_q  [FAN_SLOTS];
    logic [7:0]  prev_fault_q;
    logic [1:0]  mode_q;

    slot_report_t window_reports[$];
    tacho_row_t   plan[$];
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           out_hold = 0;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic advance_tacho(input tacho_item_t it, input logic typed,
                                 input logic [7:0] rps0);
        logic [7:0]   spd [FAN_SLOTS];
        logic [7:0]   fault_m;
        logic         clr;
        logic         do_rep;
        int unsigned  prod;
        int unsigned  q;
        slot_report_t r;
        fault_m = '0;
        clr = 1'b0;
        if (it.req == REQ_SAMPLE) begin
            for (int f = 0; f < FAN_SLOTS; f++) begin
                if (present_q[f] && it.levels[f] != lvl_q[f]) begin
                    if (it.meas && edges_q[f] != CNT_MAX) edges_q[f] = edges_q[f] + 1'b1;
                    lvl_q[f] = it.levels[f];
                end
            end
            return;
        end
        for (int f = 0; f < FAN_SLOTS; f++) begin
            spd[f] = '0;
            if (!present_q[f]) continue;
            if (it.elapsed == 0) begin
                q = RPS_MAX;
            end else begin
                prod = edges_q[f];
                q = (prod * RPS_SCALE) / it.elapsed;
                if (q > RPS_MAX) q = RPS_MAX;
            end
            spd[f] = 8'(q);
            edges_q[f] = '0;
            if (q >= min_spd_q || it.afoff[f]) slow_q[f] = '0;
            else if (slow_q[f] < err_lim_q) slow_q[f] = slow_q[f] + 1'b1;
            else if (chk_en_q) fault_m[f] = 1'b1;
        end
        if (fault_m == 0 && mode_q == MODE_REPORTED) mode_q = MODE_FIXED;
        if (mode_q == MODE_FIXED && !it.ongoing && !it.paused) begin
            mode_q = MODE_NONE;
            clr = 1'b1;
        end
        do_rep = (fault_m & ~prev_fault_q) != 0;
        prev_fault_q = fault_m;
        for (int f = 0; f < FAN_SLOTS; f++) begin
            r = '0;
            r.idx = 3'(f);
            r.rps = (f == 0 && typed) ? rps0 : spd[f];
            r.fault = fault_m[f];
            if (do_rep && fault_m[f]) begin
                r.rep = 1'b1;
                if (it.ongoing) begin
                    if (mode_q == MODE_NONE) begin
                        if (it.heat[f]) begin
                            r.kill = 1'b1;
                            mode_q = MODE_REPORTED;
                        end else begin
                            mode_q = MODE_DETECTED;
                        end
                    end
                end else if (!it.paused) begin
                    r.hoff = 1'b1;
                    if (mode_q == MODE_NONE) mode_q = MODE_REPORTED;
                end
            end
            r.mode = mode_q;
            r.clr = clr;
            r.last = (f == FAN_SLOTS - 1);
            window_reports.push_back(r);
        end
    endtask

    // called just after a falling edge; returns just after a falling edge
    task automatic offer(input tacho_item_t it, input logic typed, input logic [7:0] rps0);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = it.req;
        i_tach_levels = it.levels;
        i_measuring = it.meas;
        i_elapsed_ms = it.elapsed;
        i_job_ongoing = it.ongoing;
        i_job_paused = it.paused;
        i_heater_target_mask = it.heat;
        i_autofan_off_mask = it.afoff;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_tacho(it, typed, rps0);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (window_reports.size() != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            CFG_CHECK_EN:  chk_en_q = val[0];
            CFG_PRESENT:   present_q = val;
            CFG_ERR_LIMIT: err_lim_q = val[6:0];
            CFG_MIN_SPEED: min_spd_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic chk, input logic [7:0] pres, input logic [6:0] lim,
                             input logic [7:0] mins);
        write_reg(CFG_CHECK_EN, {7'd0, chk});
        write_reg(CFG_PRESENT, pres);
        write_reg(CFG_ERR_LIMIT, {1'b0, lim});
        write_reg(CFG_MIN_SPEED, mins);
    endtask

    function automatic tacho_row_t mk_row(input logic req, input logic [7:0] lv,
                                          input logic meas, input logic [15:0] el,
                                          input logic ong, input logic pau,
                                          input logic [7:0] heat, input logic [7:0] afoff,
                                          input logic typed, input logic [7:0] rps0);
        tacho_row_t row;
        row.it = '{req, lv, meas, el, ong, pau, heat, afoff};
        row.typed = typed;
        row.rps0 = rps0;
        return row;
    endfunction

    task automatic walk_plan();
        foreach (plan[i]) offer(plan[i].it, plan[i].typed, plan[i].rps0);
        plan.delete();
        settle();
    endtask

    function automatic tacho_item_t rand_item(input logic req);
        tacho_item_t it;
        it.req = req;
        it.levels = 8'($urandom_range(0, 255));
        it.meas = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
            0:       it.elapsed = '0;
            1:       it.elapsed = 16'($urandom_range(0, 65535));
            2:       it.elapsed = 16'hFFFF;
            default: it.elapsed = 16'($urandom_range(1, 120));
        endcase
        it.ongoing = 1'($urandom_range(0, 1));
        it.paused = ($urandom_range(0, 2) == 0);
        it.heat = 8'($urandom_range(0, 255));
        it.afoff = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        return it;
    endfunction

    task automatic run_windows(input int n_items);
        int sent;
        int nsamp;
        sent = 0;
        while (sent < n_items) begin
            nsamp = $urandom_range(0, 8);
            repeat (nsamp) offer(rand_item(REQ_SAMPLE), 1'b0, 8'd0);
            offer(rand_item(REQ_COMPUTE), 1'b0, 8'd0);
            sent += nsamp + 1;
        end
    endtask

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall = 1'b1;
            out_hold--;
        end else begin
            i_out_stall = (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : mon
        slot_report_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (window_reports.size() == 0) begin
                $error("fan_index: expected nothing, got %0d", o_fan_index);
                fail_count++;
            end else begin
                w = window_reports.pop_front();
                check_field("fan_index", w.idx, o_fan_index);
                check_field("speed_rps", w.rps, o_speed_rps);
                check_field("fan_fault", w.fault, o_fan_fault);
                check_field("fault_reported", w.rep, o_fault_reported);
                check_field("request_kill", w.kill, o_request_kill);
                check_field("heater_off", w.hoff, o_heater_off);
                check_field("error_state", w.mode, o_error_state);
                check_field("clear_alert", w.clr, o_clear_alert);
                check_field("last", w.last, o_last);
            end
        end
    end

    initial begin
        #16000000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        chk_en_q = 1'b0;
        present_q = 8'h01;
        err_lim_q = 7'd5;
        min_spd_q = 8'd20;
        prev_fault_q = '0;
        mode_q = MODE_NONE;
        for (int f = 0; f < FAN_SLOTS; f++) begin
            lvl_q[f] = 1'b0;
            edges_q[f] = '0;
            slow_q[f] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset configuration: only slot 0 fitted, checking off
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd0,     0, 0, 8'h00, 8'h00, 1, 8'd255));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd1000,  0, 0, 8'h00, 8'h00, 1, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'hFF, 1, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'h00, 1, 16'hFFFF,  1, 1, 8'hFF, 8'hFF, 0, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'hFF, 0, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd1,     0, 0, 8'h00, 8'h00, 1, 8'd255));
        plan.push_back(mk_row(REQ_SAMPLE,  8'h00, 1, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'hFF, 1, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'h00, 1, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'hFFFF,  0, 0, 8'h00, 8'h00, 1, 8'd0));
        plan.push_back(mk_row(REQ_SAMPLE,  8'hFF, 1, 16'd0,     0, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd50,    0, 0, 8'h00, 8'h00, 1, 8'd5));
        walk_plan();

        // every slot fitted and minimum speed 255: walk the error modes
        write_all(1'b1, 8'hFF, 7'd0, 8'd255);
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'h01, 8'h00, 1, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'h01, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'h00, 8'hFF, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 0, 0, 8'h00, 8'hFF, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 0, 1, 8'hFF, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 0, 0, 8'h00, 8'hFF, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 0, 0, 8'hFF, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 0, 0, 8'h00, 8'hFF, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'h00, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'hFF, 8'h00, 0, 8'd0));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd0,   1, 0, 8'h00, 8'h00, 1, 8'd255));
        plan.push_back(mk_row(REQ_COMPUTE, 8'h00, 1, 16'd100, 1, 0, 8'h02, 8'h00, 0, 8'd0));
        walk_plan();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all(1'b1, 8'hFF, 7'd0, 8'd255);
                1: write_all(1'b0, 8'h00, 7'd127, 8'd0);
                default: write_all(($urandom_range(0, 3) != 0), 8'($urandom_range(0, 255)),
                                   ($urandom_range(0, 4) == 0) ? 7'd127
                                                               : 7'($urandom_range(0, 3)),
                                   8'($urandom_range(5, 60)));
            endcase
            case (ph)
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                3, 5:    begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (ph == 4) begin
                // hold the output off while items keep coming, then drain completely
                out_hold = 200;
                run_windows(28);
                settle();
                run_windows(28);
            end else begin
                run_windows(55);
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fts_pkg.sv
rtl/fts_lane.sv
rtl/fts_merge.sv
rtl/fan_tacho_speed_monitor.sv
verif/tb_top.sv
